/* rtl/lrjs_pkg.sv */
// Package for the longest-remaining-job scheduler.
// Holds default sizes, request and status codes, and transfer payload types.
// No dependencies.
package lrjs_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int BURST_BITS_DEF = 16;

    // Request kinds
    localparam logic REQ_ARRIVE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_RAN    = 2'd0;
    localparam logic [1:0] STAT_IDLE   = 2'd1;
    localparam logic [1:0] STAT_ACCEPT = 2'd2;
    localparam logic [1:0] STAT_REJECT = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  job_slot;
        logic [15:0] burst_len;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  run_slot;
        logic        job_done;
        logic [31:0] now_time;
    } rsp_item_t;

    // Slot table write controls
    typedef struct packed {
        logic wr_en;
        logic set_live;
        logic clr_live;
    } tbl_ctl_t;

endpackage

/* rtl/lrjs_table.sv */
// Slot table: remaining-burst memory with one write and one registered read
// port, plus the per-slot live flags. Depends on lrjs_pkg.
module lrjs_table #(
    parameter int SLOTS      = lrjs_pkg::SLOTS_DEF,
    parameter int BURST_BITS = lrjs_pkg::BURST_BITS_DEF,
    localparam int SW        = $clog2(SLOTS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrjs_pkg::tbl_ctl_t    ctl,
    input  logic [SW-1:0]         wr_addr,
    input  logic [BURST_BITS-1:0] wr_data,
    input  logic [SW-1:0]         rd_addr,
    output logic [BURST_BITS-1:0] rd_data,
    output logic [SLOTS-1:0]      live
);

    logic [BURST_BITS-1:0] mem [SLOTS];
    logic [BURST_BITS-1:0] rd_data_reg;
    logic [SLOTS-1:0]      live_reg;

    // Write the burst memory and register the read data
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Set or drop live flags at the write address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else if (ctl.set_live)
        begin
            live_reg[wr_addr] <= 1'b1;
        end
        else if (ctl.clr_live)
        begin
            live_reg[wr_addr] <= 1'b0;
        end
    end

    assign rd_data = rd_data_reg;
    assign live    = live_reg;

endmodule

/* rtl/longest_remaining_job_scheduler.sv */
// Arrival: taken in IDLE, then passed through EMIT to the output register; requests stall outside IDLE.
// Tick: one pass over all SLOTS entries in SCAN through the single memory read port
// and one comparator, then UPDATE writes back the chosen job and EMIT hands on the result.
// A result held in the output register does not block the next accept; the one after waits.
// Reset (rst_n low, asynchronous) clears live flags, time and control state.
// Top level of the longest-remaining-job scheduler; uses lrjs_pkg, lrjs_table.
module longest_remaining_job_scheduler #(
    parameter int SLOTS      = lrjs_pkg::SLOTS_DEF,
    parameter int BURST_BITS = lrjs_pkg::BURST_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  lrjs_pkg::req_item_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output lrjs_pkg::rsp_item_t rsp_data
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  pv_reg, pv_next;
    logic [SW-1:0]         pidx_reg, pidx_next;
    logic                  found_reg, found_next;
    logic [SW-1:0]         best_reg, best_next;
    logic [BURST_BITS-1:0] best_val_reg, best_val_next;
    logic [31:0]           time_reg, time_next;
    lrjs_pkg::rsp_item_t   res_reg, res_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    lrjs_pkg::rsp_item_t   rsp_data_reg, rsp_data_next;

    lrjs_pkg::tbl_ctl_t    ctl;
    logic [SW-1:0]         wr_addr;
    logic [BURST_BITS-1:0] wr_data;
    logic [BURST_BITS-1:0] rd_data;
    logic [SLOTS-1:0]      live;

    logic                  req_xfer;
    logic [8:0]            slot_ext;
    logic                  in_range;
    logic [SW-1:0]         arr_idx;
    logic [BURST_BITS-1:0] arr_burst;
    logic                  arr_ok;
    logic [BURST_BITS-1:0] dec_val;
    logic [8:0]            best_ext;

    lrjs_table #(
        .SLOTS      (SLOTS),
        .BURST_BITS (BURST_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (cnt_reg[SW-1:0]),
        .rd_data (rd_data),
        .live    (live)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;

    // Decode the arrival
    assign slot_ext  = {5'd0, req_data.job_slot};
    assign in_range  = (slot_ext < 9'(SLOTS));
    assign arr_idx   = slot_ext[SW-1:0];
    assign arr_burst = BURST_BITS'(req_data.burst_len);
    assign arr_ok    = in_range && (arr_burst != '0) && !live[arr_idx];

    assign dec_val   = best_val_reg - 1'b1;
    assign best_ext  = 9'(best_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pv_next        = 1'b0;
        pidx_next      = cnt_reg[SW-1:0];
        found_next     = found_reg;
        best_next      = best_reg;
        best_val_next  = best_val_reg;
        time_next      = time_reg;
        res_next       = res_reg;
        ctl            = '0;
        wr_addr        = arr_idx;
        wr_data        = arr_burst;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    res_next.run_slot = '0;
                    res_next.job_done = 1'b0;
                    res_next.now_time = time_reg;
                    if (req_data.req_type == lrjs_pkg::REQ_ARRIVE)
                    begin
                        ctl.wr_en       = arr_ok;
                        ctl.set_live    = arr_ok;
                        res_next.status = arr_ok ? lrjs_pkg::STAT_ACCEPT
                                                 : lrjs_pkg::STAT_REJECT;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        time_next  = time_reg + 32'd1;
                        cnt_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue the next read, then compare the data that just returned
                if (cnt_reg != CW'(SLOTS))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    pv_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
                if (pv_reg && live[pidx_reg] &&
                    (!found_reg || (rd_data > best_val_reg)))
                begin
                    found_next    = 1'b1;
                    best_next     = pidx_reg;
                    best_val_next = rd_data;
                end
            end
            ST_UPDATE:
            begin
                // Run the chosen job for one unit
                wr_addr           = best_reg;
                wr_data           = dec_val;
                ctl.wr_en         = found_reg;
                ctl.clr_live      = found_reg && (dec_val == '0);
                res_next.now_time = time_reg;
                if (found_reg)
                begin
                    res_next.status   = lrjs_pkg::STAT_RAN;
                    res_next.run_slot = best_ext[3:0];
                    res_next.job_done = (dec_val == '0);
                end
                else
                begin
                    res_next.status   = lrjs_pkg::STAT_IDLE;
                    res_next.run_slot = '0;
                    res_next.job_done = 1'b0;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hand the result to the output register once it is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            time_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            time_reg      <= time_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

/* rtl/lrjs_checker.sv */
// Port-level checks for the scheduler, bound to the top level.
// Depends on lrjs_pkg and longest_remaining_job_scheduler.
module lrjs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input lrjs_pkg::req_item_t req_data,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input lrjs_pkg::rsp_item_t rsp_data
);

    // Busy for at least the cycle after a transfer in
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken back to back");

    // Idle ticks and arrivals name no slot and no completion
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_data.status != lrjs_pkg::STAT_RAN))
            |-> (rsp_data.run_slot == 4'd0 && !rsp_data.job_done))
        else $error("slot or done flag on a result that ran no job");

    // With the output free, the result data after an arrival's EMIT state carries an arrival status
    a_arrival_src: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_data.req_type == lrjs_pkg::REQ_ARRIVE &&
         (!rsp_valid || !rsp_stall))
            |=> ##1 (rsp_data.status == lrjs_pkg::STAT_ACCEPT ||
                     rsp_data.status == lrjs_pkg::STAT_REJECT))
        else $error("arrival gave a tick status");

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
        else $error("stalled result changed");

endmodule

bind longest_remaining_job_scheduler lrjs_checker u_lrjs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

/* tb/lrjs_schedule_checker.sv */
// Transfer checker for the longest-remaining-job scheduler: keeps its own slot
// table, predicts the result of each accepted request and compares results.
// Depends on lrjs_pkg for payload types and request and status codes.
module lrjs_schedule_checker #(
    parameter int SLOTS = lrjs_pkg::SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  lrjs_pkg::req_item_t req_data,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  lrjs_pkg::rsp_item_t rsp_data,
    output int unsigned         fail_count,
    output int unsigned         pending,
    output int unsigned         ran_count,
    output int unsigned         idle_count,
    output int unsigned         accept_count,
    output int unsigned         reject_count,
    output int unsigned         finish_count
);

    // Predicted scheduler state
    logic        slot_live [SLOTS];
    logic [15:0] slot_left [SLOTS];
    logic [31:0] sched_time;

    lrjs_pkg::rsp_item_t due_results [$];

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
            fail_count++;
        end
    endtask

    // Apply one request to the predicted table and return its result
    function automatic lrjs_pkg::rsp_item_t schedule_outcome(input lrjs_pkg::req_item_t item);
        lrjs_pkg::rsp_item_t res;
        bit                  found;
        int                  best;
        logic [15:0]         best_left;
        begin
            res       = '0;
            found     = 1'b0;
            best      = 0;
            best_left = '0;
            if (item.req_type == lrjs_pkg::REQ_ARRIVE)
            begin
                // Refuse a slot past the table, a busy slot or an empty burst
                if (int'(item.job_slot) >= SLOTS || slot_live[item.job_slot] ||
                    item.burst_len == 16'd0)
                begin
                    res.status = lrjs_pkg::STAT_REJECT;
                end
                else
                begin
                    slot_live[item.job_slot] = 1'b1;
                    slot_left[item.job_slot] = item.burst_len;
                    res.status = lrjs_pkg::STAT_ACCEPT;
                end
            end
            else
            begin
                // Pick the largest remaining burst; strict compare keeps the lowest slot
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_live[i] && (!found || slot_left[i] > best_left))
                    begin
                        found     = 1'b1;
                        best      = i;
                        best_left = slot_left[i];
                    end
                end
                sched_time = sched_time + 32'd1;
                if (!found)
                begin
                    res.status = lrjs_pkg::STAT_IDLE;
                end
                else
                begin
                    slot_left[best] = slot_left[best] - 16'd1;
                    res.status   = lrjs_pkg::STAT_RAN;
                    res.run_slot = best[3:0];
                    if (slot_left[best] == 16'd0)
                    begin
                        slot_live[best] = 1'b0;
                        res.job_done    = 1'b1;
                    end
                end
            end
            res.now_time = sched_time;
            return res;
        end
    endfunction

    // Predict on each request transfer, compare on each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        lrjs_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_live[i] = 1'b0;
                slot_left[i] = '0;
            end
            sched_time = '0;
            due_results.delete();
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                want = schedule_outcome(req_data);
                due_results.insert(due_results.size(), want);
                case (want.status)
                    lrjs_pkg::STAT_RAN:    ran_count++;
                    lrjs_pkg::STAT_IDLE:   idle_count++;
                    lrjs_pkg::STAT_ACCEPT: accept_count++;
                    default:               reject_count++;
                endcase
                if (want.job_done)
                begin
                    finish_count++;
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(rsp_data.status), 32'd0);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp_data.status !== want.status)
                    begin
                        report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
                    end
                    if (rsp_data.run_slot !== want.run_slot)
                    begin
                        report_mismatch("run_slot", 32'(rsp_data.run_slot),
                                        32'(want.run_slot));
                    end
                    if (rsp_data.job_done !== want.job_done)
                    begin
                        report_mismatch("job_done", 32'(rsp_data.job_done),
                                        32'(want.job_done));
                    end
                    if (rsp_data.now_time !== want.now_time)
                    begin
                        report_mismatch("now_time", rsp_data.now_time, want.now_time);
                    end
                end
            end
        end
        pending = $unsigned(due_results.size());
    end

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        ran_count    = 0;
        idle_count   = 0;
        accept_count = 0;
        reject_count = 0;
        finish_count = 0;
    end

endmodule

/* tb/longest_remaining_job_scheduler_test.sv */
// Top of the scheduler testbench: clock, reset, request and result traffic,
// watchdog and verdict. Depends on lrjs_pkg, lrjs_schedule_checker and the block.
module longest_remaining_job_scheduler_test;

    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 40;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    lrjs_pkg::req_item_t req_data;
    logic                rsp_valid;
    logic                rsp_stall;
    lrjs_pkg::rsp_item_t rsp_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned ran_count;
    int unsigned idle_count;
    int unsigned accept_count;
    int unsigned reject_count;
    int unsigned finish_count;

    int unsigned sent_items;
    int unsigned stuck_cycles;
    bit          calm;
    bit          hold_due;

    longest_remaining_job_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    lrjs_schedule_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_data     (req_data),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp_data     (rsp_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .ran_count    (ran_count),
        .idle_count   (idle_count),
        .accept_count (accept_count),
        .reject_count (reject_count),
        .finish_count (finish_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Offer one request and hold it until the transfer, then maybe idle
    task automatic send_request(input lrjs_pkg::req_item_t item);
        begin
            req_valid <= 1'b1;
            req_data  <= item;
            do
                @(posedge clk);
            while (req_stall);
            sent_items++;
            if (!calm && $urandom_range(0, 99) < 28)
            begin
                req_valid <= 1'b0;
                req_data  <= lrjs_pkg::req_item_t'($urandom);
                do
                    @(posedge clk);
                while ($urandom_range(0, 99) < 28);
            end
        end
    endtask

    function automatic lrjs_pkg::req_item_t arrival(input int slot, input int burst);
        lrjs_pkg::req_item_t item;
        begin
            item.req_type  = lrjs_pkg::REQ_ARRIVE;
            item.job_slot  = slot[3:0];
            item.burst_len = burst[15:0];
            return item;
        end
    endfunction

    function automatic lrjs_pkg::req_item_t tick_item();
        lrjs_pkg::req_item_t item;
        begin
            item          = lrjs_pkg::req_item_t'($urandom);
            item.req_type = lrjs_pkg::REQ_TICK;
            return item;
        end
    endfunction

    // Result side: random stalls, one long hold-off while requests keep coming
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_due)
            begin
                hold_due = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                rsp_stall <= !calm && ($urandom_range(0, 99) < 28);
            end
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, pending);
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        lrjs_pkg::req_item_t item;
        int                  burst;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        sent_items   = 0;
        stuck_cycles = 0;
        calm         = 1'b0;
        hold_due     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick, ties, busy slot, empty burst, finishing jobs
        send_request(tick_item());
        send_request(arrival(5, 2));
        send_request(arrival(9, 2));
        send_request(arrival(5, 16'hFFFF));
        send_request(arrival(0, 0));
        repeat (5) send_request(tick_item());
        send_request(arrival(15, 3));
        send_request(arrival(0, 1));
        send_request(arrival(7, 3));
        repeat (8) send_request(tick_item());

        // Random: mostly short bursts so jobs finish, long ones near the end
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            calm = (k >= 200 && k < 300);
            if (k == 120)
            begin
                hold_due = 1'b1;
            end
            if ($urandom_range(0, 99) < 60)
            begin
                item = tick_item();
            end
            else
            begin
                if (k >= 420 && $urandom_range(0, 3) == 0)
                begin
                    burst = $urandom_range(1, 65535);
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    burst = 0;
                end
                else
                begin
                    burst = $urandom_range(1, 6);
                end
                item = arrival($urandom_range(0, 15), burst);
            end
            send_request(item);
        end
        req_valid <= 1'b0;

        // Drain outstanding results, then allow for stray ones
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d arrivals taken, %0d refused", sent_items,
                 accept_count, reject_count);
        $display("Ticks: %0d ran a job (%0d jobs finished), %0d idle", ran_count,
                 finish_count, idle_count);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
